/* rtl/ccfp_pkg.sv */
// shared types, codes and constants of the crlf command framer pool
package ccfp_pkg;

    localparam int NUM_SLOTS_DEF  = 8;
    localparam int SLOT_BYTES_DEF = 256;
    localparam int FIFO_DEPTH_DEF = 8;

    localparam int TDATA_W = 24;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam int HDR_BYTES    = 2;
    localparam int MIN_KEEP_LEN = 3;

    typedef enum logic [2:0] {
        REQ_BYTE    = 3'd0,
        REQ_POP     = 3'd1,
        REQ_RELEASE = 3'd2,
        REQ_DISCARD = 3'd3,
        REQ_READ    = 3'd4
    } req_code_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FIFO_EMPTY = 3'd1,
        ST_REFUSED    = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_SHORT      = 3'd4,
        ST_FULL_DROP  = 3'd5,
        ST_QUEUED     = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_CLOSE,
        S_POP_LEN,
        S_POP_DONE,
        S_DISC,
        S_DISC_CLR,
        S_RD_WAIT,
        S_FIN
    } ctrl_state_t;

    // request fields, last field in the low bits
    typedef struct packed {
        logic [7:0] offset;
        logic [2:0] slot_sel;
        logic [7:0] in_byte;
        logic [2:0] req_type;
    } req_t;

    // result fields, last field in the low bits
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] length;
        logic [2:0] slot;
        status_t    status;
    } result_t;

endpackage

/* rtl/ccfp_ram.sv */
// generic simple dual-port ram with registered read
module ccfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ccfp_free_search.sv */
// rotating priority encoder: first free slot after the active one
module ccfp_free_search #(
    parameter int NUM_SLOTS = 8,
    localparam int SLOT_W = $clog2(NUM_SLOTS)
) (
    input  logic [NUM_SLOTS-1:0] busy,
    input  logic [SLOT_W-1:0]    active,
    output logic                 found,
    output logic [SLOT_W-1:0]    idx
);

    logic [SLOT_W:0] cand;

    // walk downward so the nearest slot after active wins
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        cand  = '0;
        for (int i = NUM_SLOTS - 1; i >= 1; i--)
        begin
            cand = (SLOT_W + 1)'(active) + (SLOT_W + 1)'(i);
            if (cand >= (SLOT_W + 1)'(NUM_SLOTS))
            begin
                cand = cand - (SLOT_W + 1)'(NUM_SLOTS);
            end
            if (!busy[cand[SLOT_W-1:0]])
            begin
                found = 1'b1;
                idx   = cand[SLOT_W-1:0];
            end
        end
    end

endmodule

/* rtl/ccfp_ctrl.sv */
// request sequencer: framing state, busy bits, fifo pointers and memory accesses
module ccfp_ctrl
    import ccfp_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
    localparam int SLOT_W = $clog2(NUM_SLOTS),
    localparam int POS_W  = $clog2(SLOT_BYTES),
    localparam int ST_AW  = $clog2(NUM_SLOTS * SLOT_BYTES),
    localparam int FPTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output logic              st_we,
    output logic [ST_AW-1:0]  st_waddr,
    output logic [7:0]        st_wdata,
    output logic [ST_AW-1:0]  st_raddr,
    input  logic [7:0]        st_rdata,
    output logic              fl_we,
    output logic [SLOT_W-1:0] fl_waddr,
    output logic [POS_W-1:0]  fl_wdata,
    output logic [SLOT_W-1:0] fl_raddr,
    input  logic [POS_W-1:0]  fl_rdata,
    output logic              ff_we,
    output logic [FPTR_W-1:0] ff_waddr,
    output logic [SLOT_W-1:0] ff_wdata,
    output logic [FPTR_W-1:0] ff_raddr,
    input  logic [SLOT_W-1:0] ff_rdata
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int OFF_W = ((POS_W > 8) ? POS_W : 8) + 1;

    ctrl_state_t state_reg, state_next;

    logic [2:0]           req_type_reg, req_type_next;
    logic [7:0]           byte_reg, byte_next;
    logic [2:0]           sel_reg, sel_next;
    logic [7:0]           off_reg, off_next;
    logic [SLOT_W-1:0]    active_slot_reg, active_slot_next;
    logic [POS_W-1:0]     write_pos_reg, write_pos_next;
    logic                 prev_cr_reg, prev_cr_next;
    logic                 closed_reg, closed_next;
    logic [NUM_SLOTS-1:0] busy_reg, busy_next;
    logic [FPTR_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    result_t              res_reg, res_next;

    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] eff_slot;
    logic [POS_W-1:0]  eff_pos;
    logic              eff_prev;
    logic              sel_ok;
    logic [SLOT_W-1:0] sel_idx;
    logic [OFF_W-1:0]  rd_off;
    logic [FPTR_W-1:0] head_inc;
    logic [SUM_W-1:0]  tail_sum;
    logic [ST_AW-1:0]  active_base;

    ccfp_free_search #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_search (
        .busy  (busy_reg),
        .active(active_slot_reg),
        .found (free_found),
        .idx   (free_idx)
    );

    assign sel_ok    = 32'(sel_reg) < 32'(NUM_SLOTS);
    assign sel_idx   = SLOT_W'(sel_reg);
    assign rd_off    = OFF_W'(off_reg) + OFF_W'(HDR_BYTES);
    assign head_inc  = (32'(head_reg) == FIFO_DEPTH - 1) ? '0 : head_reg + FPTR_W'(1);
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_FIN);
    assign res       = res_reg;

    // a closed slot hands over to the next free one before the byte lands
    always_comb
    begin
        if (closed_reg)
        begin
            eff_slot = free_idx;
            eff_pos  = '0;
            eff_prev = 1'b0;
        end
        else
        begin
            eff_slot = active_slot_reg;
            eff_pos  = write_pos_reg;
            eff_prev = prev_cr_reg;
        end
    end

    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(FIFO_DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(FIFO_DEPTH);
        end
    end

    assign active_base = ST_AW'(active_slot_reg) * ST_AW'(SLOT_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            active_slot_reg <= '0;
            write_pos_reg   <= '0;
            prev_cr_reg     <= 1'b0;
            closed_reg      <= 1'b0;
            busy_reg        <= '0;
            head_reg        <= '0;
            count_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            active_slot_reg <= active_slot_next;
            write_pos_reg   <= write_pos_next;
            prev_cr_reg     <= prev_cr_next;
            closed_reg      <= closed_next;
            busy_reg        <= busy_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        byte_reg     <= byte_next;
        sel_reg      <= sel_next;
        off_reg      <= off_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        req_type_next    = req_type_reg;
        byte_next        = byte_reg;
        sel_next         = sel_reg;
        off_next         = off_reg;
        active_slot_next = active_slot_reg;
        write_pos_next   = write_pos_reg;
        prev_cr_next     = prev_cr_reg;
        closed_next      = closed_reg;
        busy_next        = busy_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        res_next         = res_reg;

        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = '0;
        st_raddr = '0;
        fl_we    = 1'b0;
        fl_waddr = '0;
        fl_wdata = '0;
        fl_raddr = '0;
        ff_we    = 1'b0;
        ff_waddr = '0;
        ff_wdata = '0;
        ff_raddr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_type_next = req.req_type;
                    byte_next     = req.in_byte;
                    sel_next      = req.slot_sel;
                    off_next      = req.offset;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_FIN;
                unique case (req_type_reg)
                    REQ_BYTE:
                    begin
                        if (closed_reg && !free_found)
                        begin
                            res_next.status = ST_REFUSED;
                        end
                        else
                        begin
                            res_next.slot    = 3'(eff_slot);
                            active_slot_next = eff_slot;
                            closed_next      = 1'b0;
                            st_we            = 1'b1;
                            st_waddr = ST_AW'(eff_slot) * ST_AW'(SLOT_BYTES) + ST_AW'(eff_pos);
                            st_wdata = byte_reg;
                            if (eff_prev && byte_reg == CH_LF && eff_pos > POS_W'(1))
                            begin
                                // line complete: terminator and queueing next cycle
                                write_pos_next = eff_pos;
                                prev_cr_next   = eff_prev;
                                closed_next    = 1'b1;
                                state_next     = S_CLOSE;
                            end
                            else if (eff_pos == POS_W'(SLOT_BYTES - 1))
                            begin
                                res_next.status = ST_OVERFLOW;
                                write_pos_next  = '0;
                                prev_cr_next    = 1'b0;
                            end
                            else
                            begin
                                res_next.status = ST_OK;
                                write_pos_next  = eff_pos + POS_W'(1);
                                prev_cr_next    = (byte_reg == CH_CR);
                            end
                        end
                    end

                    REQ_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_FIFO_EMPTY;
                        end
                        else
                        begin
                            ff_raddr   = head_reg;
                            state_next = S_POP_LEN;
                        end
                    end

                    REQ_RELEASE:
                    begin
                        if (sel_ok)
                        begin
                            busy_next[sel_idx] = 1'b0;
                        end
                    end

                    REQ_DISCARD:
                    begin
                        state_next = S_DISC;
                    end

                    REQ_READ:
                    begin
                        if (sel_ok && rd_off < OFF_W'(SLOT_BYTES))
                        begin
                            st_raddr   = ST_AW'(sel_idx) * ST_AW'(SLOT_BYTES) + ST_AW'(rd_off);
                            state_next = S_RD_WAIT;
                        end
                    end

                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end

            S_CLOSE:
            begin
                // the cr before the lf becomes the terminator
                st_we      = 1'b1;
                st_waddr   = active_base + ST_AW'(write_pos_reg - POS_W'(1));
                st_wdata   = '0;
                fl_we      = 1'b1;
                fl_waddr   = active_slot_reg;
                fl_wdata   = write_pos_reg;
                state_next = S_FIN;
                if (write_pos_reg <= POS_W'(MIN_KEEP_LEN - 1))
                begin
                    busy_next[active_slot_reg] = 1'b0;
                    res_next.status            = ST_SHORT;
                end
                else if (count_reg >= CNT_W'(FIFO_DEPTH))
                begin
                    busy_next[active_slot_reg] = 1'b0;
                    res_next.status            = ST_FULL_DROP;
                end
                else
                begin
                    ff_we                      = 1'b1;
                    ff_waddr                   = tail_sum[FPTR_W-1:0];
                    ff_wdata                   = active_slot_reg;
                    count_next                 = count_reg + CNT_W'(1);
                    busy_next[active_slot_reg] = 1'b1;
                    res_next.status            = ST_QUEUED;
                end
            end

            S_POP_LEN:
            begin
                fl_raddr      = ff_rdata;
                res_next.slot = 3'(ff_rdata);
                head_next     = head_inc;
                count_next    = count_reg - CNT_W'(1);
                state_next    = S_POP_DONE;
            end

            S_POP_DONE:
            begin
                if (fl_rdata >= POS_W'(HDR_BYTES))
                begin
                    res_next.length = 8'(fl_rdata - POS_W'(HDR_BYTES));
                end
                state_next = S_FIN;
            end

            S_DISC:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ff_raddr   = head_reg;
                    state_next = S_DISC_CLR;
                end
            end

            S_DISC_CLR:
            begin
                busy_next[ff_rdata] = 1'b0;
                head_next           = head_inc;
                count_next          = count_reg - CNT_W'(1);
                state_next          = S_DISC;
            end

            S_RD_WAIT:
            begin
                res_next.data_byte = st_rdata;
                state_next         = S_FIN;
            end

            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("fifo count beyond depth");

    a_queued_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLOSE && res_next.status == ST_QUEUED) |=> busy_reg[active_slot_reg])
        else $error("queued frame slot not marked busy");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(st_we || fl_we || ff_we))
        else $error("memory write while idle");

endmodule

/* rtl/ccfp_out_stage.sv */
// output register holding one result until the sink takes it
module ccfp_out_stage
    import ccfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               res_valid,
    output logic               res_ready,
    input  result_t            res,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata
);

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign res_ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
            if (res_valid)
            begin
                data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = TDATA_W'(data_reg);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed before it was taken");

endmodule

/* rtl/crlf_command_framer_pool_unit.sv */
// top level of the crlf command framer pool
// request to result: a plain byte, release or unused code goes straight to the result; a
// closing byte adds a close step and a read waits on the frame-store ram; a pop reads the
// ready fifo and then the frame-length ram; discard-all clears each queued frame in turn
// one request at a time: a new one is taken only once the previous result has been handed on
// reset clears busy bits, fifo pointers and framing state at once; the memories are not cleared
module crlf_command_framer_pool_unit
    import ccfp_pkg::*;
#(
    parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
    parameter int SLOT_BYTES = SLOT_BYTES_DEF,
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // req_type[2:0] in_byte[10:3] slot_sel[13:11] offset[21:14]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata   // status[2:0] slot[5:3] length[13:6] data_byte[21:14]
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int POS_W  = $clog2(SLOT_BYTES);
    localparam int ST_AW  = $clog2(NUM_SLOTS * SLOT_BYTES);
    localparam int FPTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    req_t    req;
    result_t res;
    logic    res_valid;
    logic    res_ready;

    logic              st_we;
    logic [ST_AW-1:0]  st_waddr;
    logic [7:0]        st_wdata;
    logic [ST_AW-1:0]  st_raddr;
    logic [7:0]        st_rdata;
    logic              fl_we;
    logic [SLOT_W-1:0] fl_waddr;
    logic [POS_W-1:0]  fl_wdata;
    logic [SLOT_W-1:0] fl_raddr;
    logic [POS_W-1:0]  fl_rdata;
    logic              ff_we;
    logic [FPTR_W-1:0] ff_waddr;
    logic [SLOT_W-1:0] ff_wdata;
    logic [FPTR_W-1:0] ff_raddr;
    logic [SLOT_W-1:0] ff_rdata;

    assign req.req_type = s_tdata[2:0];
    assign req.in_byte  = s_tdata[10:3];
    assign req.slot_sel = s_tdata[13:11];
    assign req.offset   = s_tdata[21:14];

    ccfp_ram #(
        .WIDTH(8),
        .DEPTH(NUM_SLOTS * SLOT_BYTES)
    ) u_frame_store (
        .clk  (clk),
        .we   (st_we),
        .waddr(st_waddr),
        .wdata(st_wdata),
        .raddr(st_raddr),
        .rdata(st_rdata)
    );

    ccfp_ram #(
        .WIDTH(POS_W),
        .DEPTH(NUM_SLOTS)
    ) u_frame_length (
        .clk  (clk),
        .we   (fl_we),
        .waddr(fl_waddr),
        .wdata(fl_wdata),
        .raddr(fl_raddr),
        .rdata(fl_rdata)
    );

    ccfp_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(FIFO_DEPTH)
    ) u_ready_fifo (
        .clk  (clk),
        .we   (ff_we),
        .waddr(ff_waddr),
        .wdata(ff_wdata),
        .raddr(ff_raddr),
        .rdata(ff_rdata)
    );

    ccfp_ctrl #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_BYTES(SLOT_BYTES),
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(s_tvalid),
        .req_ready(s_tready),
        .req      (req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .st_we    (st_we),
        .st_waddr (st_waddr),
        .st_wdata (st_wdata),
        .st_raddr (st_raddr),
        .st_rdata (st_rdata),
        .fl_we    (fl_we),
        .fl_waddr (fl_waddr),
        .fl_wdata (fl_wdata),
        .fl_raddr (fl_raddr),
        .fl_rdata (fl_rdata),
        .ff_we    (ff_we),
        .ff_waddr (ff_waddr),
        .ff_wdata (ff_wdata),
        .ff_raddr (ff_raddr),
        .ff_rdata (ff_rdata)
    );

    ccfp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* dv/crlf_command_framer_pool_unit_checker.sv */
// checker for the crlf command framer pool: predicts every response and compares it with the dut
module crlf_command_framer_pool_unit_checker
    import ccfp_pkg::*;
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    input  logic                                     s_tready,
    input  logic [TDATA_W-1:0]                       s_tdata,
    input  logic                                     m_tvalid,
    input  logic                                     m_tready,
    input  logic [TDATA_W-1:0]                       m_tdata,
    output logic [NUM_SLOTS_DEF*SLOT_BYTES_DEF-1:0]  stored_mask,
    output int                                       owed_count,
    output int                                       mismatch_count,
    output int                                       frames_queued,
    output int                                       bytes_refused,
    output int                                       lines_overflowed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_BYTES = NUM_SLOTS_DEF * SLOT_BYTES_DEF;

    // shadow of the framer state
    logic [7:0]               pool_mem [POOL_BYTES];
    logic [7:0]               line_len [NUM_SLOTS_DEF];
    logic [NUM_SLOTS_DEF-1:0] busy = '0;
    logic [2:0]               ring [FIFO_DEPTH_DEF];
    int                       ring_head = 0;
    int                       ring_count = 0;
    logic [2:0]               active = '0;
    int                       wpos = 0;
    logic                     after_cr = 1'b0;
    logic                     closed = 1'b0;

    logic [POOL_BYTES-1:0]    written = '0;
    result_t                  owed_results [$];
    int                       owed = 0;
    int                       mismatches = 0;
    int                       queued_n = 0;
    int                       refused_n = 0;
    int                       overflow_n = 0;

    assign stored_mask      = written;
    assign owed_count       = owed;
    assign mismatch_count   = mismatches;
    assign frames_queued    = queued_n;
    assign bytes_refused    = refused_n;
    assign lines_overflowed = overflow_n;

    // applies one request to the shadow state; store_idx is the pool byte written, or -1
    function automatic result_t frame_pool_step(input req_t r, output int store_idx);
        result_t    res;
        int         base;
        logic [2:0] pick;
        logic       found;
        res       = '0;
        res.status = ST_OK;
        store_idx = -1;
        pick      = '0;
        case (req_code_t'(r.req_type))
            REQ_BYTE: begin
                found = 1'b1;
                if (closed) begin
                    // round-robin search that never picks the active slot
                    found = 1'b0;
                    for (int i = 1; i < NUM_SLOTS_DEF; i++) begin
                        if (!found && !busy[(active + i) % NUM_SLOTS_DEF]) begin
                            found = 1'b1;
                            pick  = 3'((active + i) % NUM_SLOTS_DEF);
                        end
                    end
                end
                if (!found) begin
                    res.status = ST_REFUSED;
                end else begin
                    if (closed) begin
                        active   = pick;
                        closed   = 1'b0;
                        wpos     = 0;
                        after_cr = 1'b0;
                    end
                    res.slot  = active;
                    base      = active * SLOT_BYTES_DEF;
                    pool_mem[base + wpos] = r.in_byte;
                    store_idx = base + wpos;
                    if (after_cr && r.in_byte == CH_LF && wpos > 1) begin
                        pool_mem[base + wpos - 1] = 8'h00;
                        line_len[active] = 8'(wpos);
                        closed = 1'b1;
                        if (wpos + 1 <= MIN_KEEP_LEN) begin
                            busy[active] = 1'b0;
                            res.status   = ST_SHORT;
                        end else if (ring_count >= FIFO_DEPTH_DEF) begin
                            busy[active] = 1'b0;
                            res.status   = ST_FULL_DROP;
                        end else begin
                            ring[(ring_head + ring_count) % FIFO_DEPTH_DEF] = active;
                            ring_count++;
                            busy[active] = 1'b1;
                            res.status   = ST_QUEUED;
                        end
                    end else if (wpos + 1 >= SLOT_BYTES_DEF) begin
                        wpos       = 0;
                        after_cr   = 1'b0;
                        res.status = ST_OVERFLOW;
                    end else begin
                        wpos++;
                        after_cr = (r.in_byte == CH_CR);
                    end
                end
            end
            REQ_POP: begin
                if (ring_count == 0) begin
                    res.status = ST_FIFO_EMPTY;
                end else begin
                    pick       = ring[ring_head];
                    res.slot   = pick;
                    res.length = (line_len[pick] >= HDR_BYTES) ?
                                 8'(line_len[pick] - HDR_BYTES) : 8'h00;
                    ring_head  = (ring_head + 1) % FIFO_DEPTH_DEF;
                    ring_count--;
                end
            end
            REQ_RELEASE: busy[r.slot_sel] = 1'b0;
            REQ_DISCARD: begin
                while (ring_count > 0) begin
                    busy[ring[ring_head]] = 1'b0;
                    ring_head = (ring_head + 1) % FIFO_DEPTH_DEF;
                    ring_count--;
                end
            end
            REQ_READ: begin
                if (r.offset + HDR_BYTES < SLOT_BYTES_DEF)
                    res.data_byte = pool_mem[r.slot_sel * SLOT_BYTES_DEF + r.offset + HDR_BYTES];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk) begin : watch
        result_t got;
        result_t want;
        req_t    r;
        int      idx;
        if (rst_n) begin
            // results leave only after their request has been taken, so check first
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (owed_results.size() == 0) begin
                    $error("response %h with no request outstanding", m_tdata);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, got.slot);
                        mismatches++;
                    end
                    if (got.length !== want.length) begin
                        $error("length: expected %0d, got %0d", want.length, got.length);
                        mismatches++;
                    end
                    if (got.data_byte !== want.data_byte) begin
                        $error("data_byte: expected %h, got %h", want.data_byte, got.data_byte);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                r    = req_t'(s_tdata[$bits(req_t)-1:0]);
                want = frame_pool_step(r, idx);
                owed_results.push_back(want);
                if (idx >= 0)
                    written[idx] <= 1'b1;
                if (want.status == ST_QUEUED)
                    queued_n++;
                if (want.status == ST_REFUSED)
                    refused_n++;
                if (want.status == ST_OVERFLOW)
                    overflow_n++;
            end
            owed <= owed_results.size();
        end
    end

endmodule

/* dv/crlf_command_framer_pool_unit_test.sv */
// testbench top for the crlf command framer pool: request stimulus, stalls and verdict
module crlf_command_framer_pool_unit_test
    import ccfp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         ITEMS_TARGET     = 1750;
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    logic                                    clk;
    logic                                    rst_n;
    logic                                    s_tvalid;
    logic                                    s_tready;
    logic [TDATA_W-1:0]                      s_tdata;
    logic                                    m_tvalid;
    logic                                    m_tready;
    logic [TDATA_W-1:0]                      m_tdata;
    logic [NUM_SLOTS_DEF*SLOT_BYTES_DEF-1:0] stored_mask;
    int                                      owed_count;
    int                                      mismatch_count;
    int                                      frames_queued;
    int                                      bytes_refused;
    int                                      lines_overflowed;

    logic calm;
    int   items_sent;
    int   kind_count [5];

    crlf_command_framer_pool_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    crlf_command_framer_pool_unit_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .stored_mask      (stored_mask),
        .owed_count       (owed_count),
        .mismatch_count   (mismatch_count),
        .frames_queued    (frames_queued),
        .bytes_refused    (bytes_refused),
        .lines_overflowed (lines_overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("crlf_command_framer_pool_unit_test: done, errors");
        $finish;
    end

    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= 22);

    // holds one request on the bus until the framer takes it
    task automatic send_req(input logic [2:0] code, input logic [7:0] b,
                            input logic [2:0] sel, input logic [7:0] off);
        req_t r;
        r.req_type = code;
        r.in_byte  = b;
        r.slot_sel = sel;
        r.offset   = off;
        if (!calm)
            while ($urandom_range(99) < 22)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(r);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (code <= REQ_READ)
        begin
            items_sent++;
            kind_count[code]++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(REQ_BYTE, b, 3'($urandom), 8'($urandom));
    endtask

    task automatic send_plain(input logic [2:0] code);
        send_req(code, 8'($urandom), 3'($urandom), 8'($urandom));
    endtask

    // random line body, often with stray cr and lf, usually closed by cr lf
    task automatic send_line(input int body_len, input bit terminate);
        int p;
        for (int i = 0; i < body_len; i++)
        begin
            p = $urandom_range(99);
            if (p < 8)
                send_byte(CH_CR);
            else if (p < 12)
                send_byte(CH_LF);
            else
                send_byte(8'($urandom));
        end
        if (terminate)
        begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end
    endtask

    // reads only pool bytes that have been written, else an offset past the slot
    task automatic send_read();
        logic [2:0] sel;
        logic [7:0] off;
        bit         hit;
        hit = 1'b0;
        sel = '0;
        off = '0;
        for (int t = 0; t < 24 && !hit; t++)
        begin
            sel = 3'($urandom);
            off = ($urandom_range(7) == 0) ? 8'($urandom_range(253)) : 8'($urandom_range(15));
            hit = stored_mask[sel * SLOT_BYTES_DEF + off + HDR_BYTES];
        end
        if (!hit)
            off = 8'($urandom_range(255, 254));
        send_req(REQ_READ, 8'($urandom), sel, off);
    endtask

    initial
    begin
        int  p;
        bit  hoard;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        calm       = 1'b0;
        items_sent = 0;
        foreach (kind_count[k])
            kind_count[k] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, reads past the slot end, unused codes
        send_plain(REQ_POP);
        send_req(REQ_READ, 8'hFF, 3'd7, 8'd255);
        send_req(REQ_READ, 8'h00, 3'd0, 8'd254);
        for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++)
            send_plain(3'(c));
        // lone lf, then a cr lf that closes a frame too short to keep
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        // two kept frames in the next slots, one with extreme byte values
        send_byte("A");
        send_byte("T");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_req(REQ_READ, 8'h00, 3'd1, 8'd0);
        send_req(REQ_READ, 8'hFF, 3'd2, 8'd1);
        send_plain(REQ_POP);
        send_req(REQ_RELEASE, 8'h00, 3'd1, 8'd0);
        send_plain(REQ_DISCARD);
        send_plain(REQ_POP);
        send_req(REQ_RELEASE, 8'hFF, 3'd7, 8'd255);

        // a line sized to close on the last byte of a slot, then one sized to overflow it
        send_line(254, 1'b1);
        send_plain(REQ_POP);
        send_line(257, 1'b1);

        while (items_sent < ITEMS_TARGET)
        begin
            calm  <= (items_sent >= 900 && items_sent < 1200);
            // a hoarding phase with fewer pops and releases fills the pool and the queue
            hoard = ((items_sent / 250) % 3 == 2);
            p     = $urandom_range(99);
            if (p < (hoard ? 60 : 45))
                send_line(($urandom_range(99) == 0) ? $urandom_range(258, 250) : $urandom_range(14),
                          $urandom_range(9) != 0);
            else if (p < (hoard ? 70 : 65))
                send_plain(REQ_POP);
            else if (p < (hoard ? 74 : 82))
                send_plain(REQ_RELEASE);
            else if (p < (hoard ? 75 : 85))
                send_plain(REQ_DISCARD);
            else if (p < (hoard ? 90 : 95))
                send_read();
            else if ($urandom_range(1) == 0)
                send_plain(3'($urandom_range(REQ_UNUSED_LAST, REQ_UNUSED_FIRST)));
            else
                send_byte(8'($urandom));
        end
        calm     <= 1'b0;
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (owed_count != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d requests: %0d bytes, %0d pops, %0d releases, %0d discards, %0d reads",
                 items_sent, kind_count[REQ_BYTE], kind_count[REQ_POP], kind_count[REQ_RELEASE],
                 kind_count[REQ_DISCARD], kind_count[REQ_READ]);
        $display("%0d frames queued, %0d bytes refused with no free slot, %0d lines overflowed",
                 frames_queued, bytes_refused, lines_overflowed);
        if (mismatch_count == 0 && owed_count == 0)
            $display("crlf_command_framer_pool_unit_test: done, clean");
        else
            $display("crlf_command_framer_pool_unit_test: done, errors");
        $finish;
    end

endmodule
